FILE: rtl/core/ecf_pkg.sv
`default_nettype none

package ecf_pkg;

  // Q15 unity
  localparam logic [15:0] Q_ONE = 16'd32768;

  // log10(2) in Q32
  localparam logic [63:0] LOG10_2_Q32 = 64'd1292913986;

  localparam int LOG_TABLE_POINTS_DEF = 257;

  // shared multiplier operand widths
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 3'd4;

  // curve modes
  localparam logic [1:0] CURVE_LINEAR = 2'd0;
  localparam logic [1:0] CURVE_CUBE   = 2'd1;
  localparam logic [1:0] CURVE_LOG    = 2'd2;
  localparam logic [1:0] CURVE_SCURVE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CLAMP,
    ST_SQ,
    ST_CUBE,
    ST_CUBE_END,
    ST_POS,
    ST_IDX,
    ST_ROM_A,
    ST_ROM_B,
    ST_LOG_END,
    ST_SMOOTH,
    ST_UPDATE,
    ST_DONE
  } ecf_state_t;

  // log2(u) in Q28, elaboration only
  function automatic logic [63:0] log2_q28(input logic [31:0] u);
    logic [63:0] m;
    logic [63:0] r;
    int k;
    k = 0;
    for (int j = 0; j < 32; j++) begin
      if (u[j]) k = j;
    end
    m = ({32'd0, u} << 30) >> k;
    r = 64'(k) << 28;
    for (int i = 27; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    if (u == 32'd0) r = 64'd0;
    return r;
  endfunction

  // entry i of log10(1 + 9i/(points-1)) in Q15
  function automatic logic [15:0] log_entry(input int i, input int points);
    logic [31:0] den;
    logic [63:0] diff;
    logic [63:0] v;
    den  = 32'(points - 1);
    diff = log2_q28(den + 32'(9 * i)) - log2_q28(den);
    v    = (diff * LOG10_2_Q32 + (64'd1 << 44)) >> 45;
    if (v > 64'(Q_ONE)) v = 64'(Q_ONE);
    if (i == points - 1) v = 64'(Q_ONE);
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ecf_mul.sv
`default_nettype none

module ecf_mul
  import ecf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [MUL_P_W-1:0] prod_r
);

  // unsigned product, registered
  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

`default_nettype wire

FILE: rtl/core/ecf_log_rom.sv
`default_nettype none

module ecf_log_rom
  import ecf_pkg::*;
#(
  parameter int POINTS = LOG_TABLE_POINTS_DEF,
  parameter int ADDR_W = $clog2(POINTS)
) (
  input  wire logic              clk,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [15:0]       rd_data_r
);

  logic [15:0] rom [POINTS];

  for (genvar g = 0; g < POINTS; g++) begin : g_rom
    localparam logic [15:0] ENTRY = log_entry(g, POINTS);
    assign rom[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rom[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/envelope_curve_follower_core.sv
`default_nettype none
// Envelope curve follower: threshold, gain, response curve, attack/release smoother.
// Each word steps through the sequencer states, one multiply at a time, from accept to out_valid.
// A new word is taken only once the last has left the sequencer, which uses the single shared 16x24 multiplier.
// in_stall is low only while the sequencer idles; a finished word may wait in the output reg.
// Reset (rst_n low, synchronous): smoother state 0, registers to defaults, no word pending.

module envelope_curve_follower_core
  import ecf_pkg::*;
#(
  parameter int LOG_TABLE_POINTS = LOG_TABLE_POINTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [15:0]          in_level_in,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [15:0]          out_curved_level,
  output logic      [15:0]          out_influence,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  localparam int IDX_W = $clog2(LOG_TABLE_POINTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LOG_TABLE_POINTS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Always ready; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [14:0] thr_r;
  logic [14:0] gain_r;
  logic [1:0]  mode_r;
  logic [15:0] attack_r;
  logic [15:0] release_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= 15'd0;
      gain_r    <= 15'd4096;
      mode_r    <= CURVE_LINEAR;
      attack_r  <= Q_ONE;
      release_r <= Q_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:     thr_r     <= cfg_data[14:0];
        REG_SCALE_GAIN:    gain_r    <= cfg_data[14:0];
        REG_CURVE_MODE:    mode_r    <= cfg_data[1:0];
        REG_ATTACK_COEFF:  attack_r  <= cfg_data;
        REG_RELEASE_COEFF: release_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier and log table
  // ---------------------------------------------------------------------------
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  ecf_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  logic [IDX_W-1:0] rom_addr;
  logic [15:0]      rom_q;

  ecf_log_rom #(
    .POINTS (LOG_TABLE_POINTS),
    .ADDR_W (IDX_W)
  ) u_rom (
    .clk       (clk),
    .rd_addr   (rom_addr),
    .rd_data_r (rom_q)
  );

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  ecf_state_t       state_r, state_nxt;
  logic [15:0]      excess_r, excess_nxt;   // level minus threshold, 0 below it
  logic [15:0]      x_r, x_nxt;             // clamped, scaled level
  logic [15:0]      op_r, op_nxt;           // cube operand
  logic             neg_r, neg_nxt;         // S-curve lower half
  logic [15:0]      curved_r, curved_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [14:0]      frac_r, frac_nxt;
  logic [15:0]      a_r, a_nxt;             // table point below
  logic             rising_r, rising_nxt;
  logic [23:0]      smooth_r, smooth_nxt;   // Q23 smoother state
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_curved_r, out_curved_nxt;
  logic [15:0]      out_infl_r, out_infl_nxt;

  // ---------------------------------------------------------------------------
  // Datapath terms around the multiplier
  // ---------------------------------------------------------------------------
  logic [15:0]      lvl_sat;
  logic [15:0]      excess_in;
  logic [15:0]      x_clamp;
  logic [16:0]      twice;
  logic [15:0]      s_op;
  logic [15:0]      cube_c;
  logic [16:0]      s_up;
  logic [16:0]      s_dn;
  logic [16:0]      interp_sum;
  logic [IDX_W-1:0] pos_idx;
  logic [23:0]      c23;
  logic             rising;
  logic [23:0]      diff;
  logic [15:0]      attack_k;
  logic [15:0]      release_k;
  logic [23:0]      step;

  // input level saturates at 1.0; a level equal to the threshold gives zero excess
  assign lvl_sat   = (in_level_in > Q_ONE) ? Q_ONE : in_level_in;
  assign excess_in = (lvl_sat >= {1'b0, thr_r}) ? (lvl_sat - {1'b0, thr_r}) : 16'd0;

  // (excess * gain) >> 12, saturated to 1.0
  assign x_clamp = (prod[MUL_P_W-1:12] > (MUL_P_W - 12)'(Q_ONE)) ? Q_ONE : prod[27:12];

  // S-curve operand |2x - 1|
  assign twice = {x_clamp, 1'b0};
  assign s_op  = (twice >= 17'(Q_ONE)) ? 16'(twice - 17'(Q_ONE))
                                       : 16'(17'(Q_ONE) - twice);

  // product >> 15: square, cube and interpolation all land here
  assign cube_c     = prod[30:15];
  assign s_up       = 17'(Q_ONE) + {1'b0, cube_c};
  assign s_dn       = 17'(Q_ONE) - {1'b0, cube_c};
  assign interp_sum = {1'b0, a_r} + {1'b0, cube_c};

  // table position x*(P-1): integer part indexes, low 15 bits interpolate
  assign pos_idx = prod[15 +: IDX_W];

  // smoother
  assign c23       = 24'({curved_r, 8'd0});
  assign rising    = c23 > smooth_r;
  assign diff      = rising ? (c23 - smooth_r) : (smooth_r - c23);
  assign attack_k  = (attack_r > Q_ONE) ? Q_ONE : attack_r;
  assign release_k = (release_r > Q_ONE) ? Q_ONE : release_r;
  assign step      = prod[38:15];

  // ---------------------------------------------------------------------------
  // State register and datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      smooth_r    <= 24'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      smooth_r    <= smooth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    excess_r     <= excess_nxt;
    x_r          <= x_nxt;
    op_r         <= op_nxt;
    neg_r        <= neg_nxt;
    curved_r     <= curved_nxt;
    idx_r        <= idx_nxt;
    frac_r       <= frac_nxt;
    a_r          <= a_nxt;
    rising_r     <= rising_nxt;
    out_curved_r <= out_curved_nxt;
    out_infl_r   <= out_infl_nxt;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: at most one multiply per state, product read back the cycle after.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    excess_nxt     = excess_r;
    x_nxt          = x_r;
    op_nxt         = op_r;
    neg_nxt        = neg_r;
    curved_nxt     = curved_r;
    idx_nxt        = idx_r;
    frac_nxt       = frac_r;
    a_nxt          = a_r;
    rising_nxt     = rising_r;
    smooth_nxt     = smooth_r;
    out_curved_nxt = out_curved_r;
    out_infl_nxt   = out_infl_r;
    mul_a          = '0;
    mul_b          = '0;
    rom_addr       = idx_r;
    in_stall       = 1'b1;

    // output word leaves when taken
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          excess_nxt = excess_in;
          state_nxt  = ST_SCALE;
        end
      end

      ST_SCALE: begin
        mul_a     = excess_r;
        mul_b     = MUL_B_W'(gain_r);
        state_nxt = ST_CLAMP;
      end

      ST_CLAMP: begin
        x_nxt = x_clamp;
        case (mode_r)
          CURVE_CUBE: begin
            op_nxt    = x_clamp;
            state_nxt = ST_SQ;
          end
          CURVE_SCURVE: begin
            op_nxt    = s_op;
            neg_nxt   = (twice < 17'(Q_ONE));
            state_nxt = ST_SQ;
          end
          CURVE_LOG: begin
            state_nxt = ST_POS;
          end
          default: begin
            curved_nxt = x_clamp;
            state_nxt  = ST_SMOOTH;
          end
        endcase
      end

      ST_SQ: begin
        mul_a     = op_r;
        mul_b     = MUL_B_W'(op_r);
        state_nxt = ST_CUBE;
      end

      ST_CUBE: begin
        mul_a     = op_r;
        mul_b     = MUL_B_W'(cube_c);
        state_nxt = ST_CUBE_END;
      end

      ST_CUBE_END: begin
        if (mode_r == CURVE_CUBE) begin
          curved_nxt = cube_c;
        end else if (neg_r) begin
          curved_nxt = s_dn[16:1];
        end else begin
          curved_nxt = s_up[16:1];
        end
        state_nxt = ST_SMOOTH;
      end

      ST_POS: begin
        mul_a     = x_r;
        mul_b     = MUL_B_W'(LOG_TABLE_POINTS - 1);
        state_nxt = ST_IDX;
      end

      ST_IDX: begin
        idx_nxt  = pos_idx;
        frac_nxt = prod[14:0];
        rom_addr = pos_idx;
        if (pos_idx >= IDX_LAST) begin
          // top of the table is exactly 1.0
          curved_nxt = Q_ONE;
          state_nxt  = ST_SMOOTH;
        end else begin
          state_nxt = ST_ROM_A;
        end
      end

      ST_ROM_A: begin
        a_nxt     = rom_q;
        rom_addr  = idx_r + IDX_W'(1);
        state_nxt = ST_ROM_B;
      end

      ST_ROM_B: begin
        if (rom_q < a_r) begin
          curved_nxt = a_r;
          state_nxt  = ST_SMOOTH;
        end else begin
          mul_a     = rom_q - a_r;
          mul_b     = MUL_B_W'(frac_r);
          state_nxt = ST_LOG_END;
        end
      end

      ST_LOG_END: begin
        curved_nxt = interp_sum[15:0];
        state_nxt  = ST_SMOOTH;
      end

      ST_SMOOTH: begin
        rising_nxt = rising;
        mul_a      = rising ? attack_k : release_k;
        mul_b      = diff;
        state_nxt  = ST_UPDATE;
      end

      ST_UPDATE: begin
        smooth_nxt = rising_r ? (smooth_r + step) : (smooth_r - step);
        state_nxt  = ST_DONE;
      end

      ST_DONE: begin
        // wait for a free output register
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_curved_nxt = curved_r;
          out_infl_nxt   = smooth_r[23:8];
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_curved_level = out_curved_r;
  assign out_influence    = out_infl_r;

endmodule

`default_nettype wire
